>>> hw/rtl/mi3_pkg.sv
// ---------------------------------------------------------------------------
// mi3_pkg
// Shared widths, stage map and constants of the 3x3 matrix inverse unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package mi3_pkg;

    localparam int W          = 32;         // element width, Q16.16
    localparam int NEL        = 9;          // elements per matrix
    localparam int CW         = 2 * W;      // cofactor width, Q32.32
    localparam int PLW        = CW + 1;     // element times unsigned low cofactor half
    localparam int DW         = 98;         // determinant width, Q48.48 with headroom
    localparam int RW         = DW + 1;     // divider remainder width
    localparam int THR_W      = 63;
    localparam int DIV_STAGES = W;          // one quotient bit per stage

    // stage map
    localparam int S_PROD = 0;
    localparam int S_ADJ  = 1;
    localparam int S_PP   = 2;
    localparam int S_TERM = 3;
    localparam int S_DET  = 4;
    localparam int S_MAG  = 5;
    localparam int S_CHK  = 6;
    localparam int S_DIV0 = 7;
    localparam int S_OUT  = S_DIV0 + DIV_STAGES;
    localparam int NST    = S_OUT + 1;

    localparam logic [THR_W-1:0] THR_RESET = THR_W'(2814750);
    localparam logic [W-1:0]     ONE_Q16   = W'(65536);
    localparam logic [W-1:0]     R_MAX     = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]     R_MIN     = {1'b1, {(W-1){1'b0}}};

    typedef logic [3:0] el_idx_t;
    typedef el_idx_t idx_tab_t [NEL];

    // cofactor k = e[PA_I]*e[PA_J] - e[PB_I]*e[PB_J], row-major element order
    localparam idx_tab_t PA_I = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam idx_tab_t PA_J = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam idx_tab_t PB_I = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam idx_tab_t PB_J = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

    typedef struct packed {
        logic neg;      // result sign
        logic ovf;      // quotient at least 2^32
    } lane_flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/mi3_if.sv
// ---------------------------------------------------------------------------
// mi3_if
// Matrix, result and threshold write channels of the matrix inverse unit.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface mi3_mat_if;
    logic                       valid;
    logic                       ready;
    logic signed [mi3_pkg::W-1:0] m11, m12, m13, m21, m22, m23, m31, m32, m33;
    modport source (output valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    input ready);
    modport sink   (input valid, m11, m12, m13, m21, m22, m23, m31, m32, m33,
                    output ready);
endinterface

interface mi3_inv_if;
    logic                       valid;
    logic                       ready;
    logic signed [mi3_pkg::W-1:0] r11, r12, r13, r21, r22, r23, r31, r32, r33;
    logic                       singular;
    logic                       saturated;
    modport source (output valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    singular, saturated, input ready);
    modport sink   (input valid, r11, r12, r13, r21, r22, r23, r31, r32, r33,
                    singular, saturated, output ready);
endinterface

interface mi3_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [mi3_pkg::THR_W-1:0]      data;
    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mi3_div_lane.sv
// ---------------------------------------------------------------------------
// mi3_div_lane
// Pipelined restoring divider for one element: (cm * 2^32) / dmag, one
// quotient bit per stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module mi3_div_lane
(
    input  wire logic                              clk,
    input  wire logic [mi3_pkg::DIV_STAGES-1:0]    en,
    input  wire logic [mi3_pkg::CW-1:0]            cm,
    input  wire logic [mi3_pkg::DW-1:0]            dsor [mi3_pkg::DIV_STAGES],
    input  wire mi3_pkg::lane_flags_t              flags,
    output logic [mi3_pkg::W-1:0]                  quo,
    output mi3_pkg::lane_flags_t                   flags_out
);
    import mi3_pkg::*;

    logic [RW-1:0]  rem_reg  [DIV_STAGES];
    logic [RW-1:0]  rem_next [DIV_STAGES];
    logic [W-1:0]   q_reg    [DIV_STAGES];
    logic [W-1:0]   q_next   [DIV_STAGES];
    lane_flags_t    fl_reg   [DIV_STAGES];
    lane_flags_t    fl_next  [DIV_STAGES];
    logic [RW-1:0]  rin      [DIV_STAGES];
    logic [RW-1:0]  sh       [DIV_STAGES];
    logic [W-1:0]   qin      [DIV_STAGES];
    logic           ge       [DIV_STAGES];

    always_comb
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                rin[j]     = RW'(cm);
                qin[j]     = '0;
                fl_next[j] = flags;
            end
            else
            begin
                rin[j]     = rem_reg[j-1];
                qin[j]     = q_reg[j-1];
                fl_next[j] = fl_reg[j-1];
            end
            sh[j]       = {rin[j][RW-2:0], 1'b0};
            ge[j]       = sh[j] >= RW'(dsor[j]);
            rem_next[j] = ge[j] ? (sh[j] - RW'(dsor[j])) : sh[j];
            q_next[j]   = {qin[j][W-2:0], ge[j]};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (en[j])
            begin
                rem_reg[j] <= rem_next[j];
                q_reg[j]   <= q_next[j];
                fl_reg[j]  <= fl_next[j];
            end
        end
    end

    assign quo       = q_reg[DIV_STAGES-1];
    assign flags_out = fl_reg[DIV_STAGES-1];

endmodule

`default_nettype wire

>>> hw/rtl/matrix3_inverse_unit.sv
// ---------------------------------------------------------------------------
// matrix3_inverse_unit
// Inverse of a 3x3 signed Q16.16 matrix as adjugate over exact determinant.
// ---------------------------------------------------------------------------
// Takes one matrix per cycle when the output side keeps up. The pipeline
// holds a divider array: nine lanes of a restoring divider that each
// produce one quotient bit per stage over 32 stages, behind seven stages
// that form the cofactors, the determinant and the singular and overflow
// checks, plus the output register. Stalls only hold stages that carry a
// transaction, so empty slots still fill.
// A determinant whose magnitude is below the threshold register (or zero)
// returns the identity with singular set.
`timescale 1ns / 1ps
`default_nettype none

module matrix3_inverse_unit
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    mi3_mat_if.sink    mat,
    mi3_inv_if.source  inv,
    mi3_cfg_if.sink    cfg
);
    import mi3_pkg::*;

    logic [NST-1:0]     v_reg;
    logic [NST-1:0]     en;
    logic [THR_W-1:0]   thr_reg;

    logic signed [W-1:0]    e [NEL];

    // cofactor products
    logic signed [CW-1:0]   pa_reg [NEL], pa_next [NEL];
    logic signed [CW-1:0]   pb_reg [NEL], pb_next [NEL];
    logic signed [W-1:0]    top_reg [3];
    // adjugate and carried copies
    logic signed [CW-1:0]   adj_reg [NEL], adj_next [NEL];
    logic signed [W-1:0]    top_adj_reg [3];
    logic signed [CW-1:0]   adj_pp_reg [NEL];
    logic signed [CW-1:0]   adj_term_reg [NEL];
    logic signed [CW-1:0]   adj_det_reg [NEL];
    // determinant partial products
    logic signed [CW-1:0]   ph_reg [3], ph_next [3];
    logic signed [PLW-1:0]  pl_reg [3], pl_next [3];
    logic signed [DW-1:0]   term_reg [3], term_next [3];
    logic signed [DW-1:0]   det_reg, det_next;
    // magnitudes
    logic [DW-1:0]          dmag_reg, dmag_next;
    logic                   dneg_reg;
    logic [CW-1:0]          cm_reg [NEL], cm_next [NEL];
    logic                   cneg_reg [NEL];
    // checks
    logic [DW-1:0]          dchk_reg;
    logic [CW-1:0]          cm_chk_reg [NEL];
    lane_flags_t            fl_chk_reg [NEL], fl_chk_next [NEL];
    logic                   sing_chk_reg, sing_chk_next;
    // divider side data
    logic [DW-1:0]          dsor_reg [DIV_STAGES-1];
    logic [DW-1:0]          dsor [DIV_STAGES];
    logic                   sing_div_reg [DIV_STAGES];
    logic [W-1:0]           quo [NEL];
    lane_flags_t            fl_out [NEL];
    // output
    logic [W-1:0]           r_reg [NEL], r_next [NEL];
    logic                   sing_out_reg;
    logic                   sat_out_reg, sat_out_next;
    logic [NEL-1:0]         sat_el;

    assign e[0] = mat.m11;
    assign e[1] = mat.m12;
    assign e[2] = mat.m13;
    assign e[3] = mat.m21;
    assign e[4] = mat.m22;
    assign e[5] = mat.m23;
    assign e[6] = mat.m31;
    assign e[7] = mat.m32;
    assign e[8] = mat.m33;

    // a stage may load when the output is ready or some stage at or after it is empty
    for (genvar g = 0; g < NST; g++)
    begin : g_en
        assign en[g] = inv.ready | ~(&v_reg[NST-1:g]);
    end

    assign mat.ready = en[S_PROD];
    assign cfg.ready = 1'b1;
    assign inv.valid = v_reg[NST-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg   <= '0;
            thr_reg <= THR_RESET;
        end
        else
        begin
            if (cfg.valid)
            begin
                thr_reg <= cfg.data;
            end
            for (int k = 0; k < NST; k++)
            begin
                if (en[k])
                begin
                    if (k == 0)
                    begin
                        v_reg[k] <= mat.valid;
                    end
                    else
                    begin
                        v_reg[k] <= v_reg[k-1];
                    end
                end
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NEL; k++)
        begin
            pa_next[k]  = e[PA_I[k]] * e[PA_J[k]];
            pb_next[k]  = e[PB_I[k]] * e[PB_J[k]];
            adj_next[k] = pa_reg[k] - pb_reg[k];
        end
        // det = m11*adj0 + m12*adj3 + m13*adj6, cofactor split in halves
        for (int k = 0; k < 3; k++)
        begin
            ph_next[k]   = top_adj_reg[k] * $signed(adj_reg[3*k][CW-1:W]);
            pl_next[k]   = top_adj_reg[k] * $signed({1'b0, adj_reg[3*k][W-1:0]});
            term_next[k] = DW'($signed({ph_reg[k], {W{1'b0}}})) + DW'(pl_reg[k]);
        end
        det_next  = term_reg[0] + term_reg[1] + term_reg[2];
        dmag_next = det_reg[DW-1] ? DW'(-det_reg) : DW'(det_reg);
        for (int k = 0; k < NEL; k++)
        begin
            cm_next[k]         = adj_det_reg[k][CW-1] ? CW'(-adj_det_reg[k])
                                                      : CW'(adj_det_reg[k]);
            fl_chk_next[k].neg = cneg_reg[k] ^ dneg_reg;
            fl_chk_next[k].ovf = DW'(cm_reg[k]) >= dmag_reg;
        end
        sing_chk_next = (dmag_reg < DW'(thr_reg)) || (dmag_reg == '0);
    end

    always_ff @(posedge clk)
    begin
        if (en[S_PROD])
        begin
            pa_reg <= pa_next;
            pb_reg <= pb_next;
            for (int k = 0; k < 3; k++)
            begin
                top_reg[k] <= e[k];
            end
        end
        if (en[S_ADJ])
        begin
            adj_reg     <= adj_next;
            top_adj_reg <= top_reg;
        end
        if (en[S_PP])
        begin
            ph_reg     <= ph_next;
            pl_reg     <= pl_next;
            adj_pp_reg <= adj_reg;
        end
        if (en[S_TERM])
        begin
            term_reg     <= term_next;
            adj_term_reg <= adj_pp_reg;
        end
        if (en[S_DET])
        begin
            det_reg     <= det_next;
            adj_det_reg <= adj_term_reg;
        end
        if (en[S_MAG])
        begin
            dmag_reg <= dmag_next;
            dneg_reg <= det_reg[DW-1];
            cm_reg   <= cm_next;
            for (int k = 0; k < NEL; k++)
            begin
                cneg_reg[k] <= adj_det_reg[k][CW-1];
            end
        end
        if (en[S_CHK])
        begin
            dchk_reg     <= dmag_reg;
            cm_chk_reg   <= cm_reg;
            fl_chk_reg   <= fl_chk_next;
            sing_chk_reg <= sing_chk_next;
        end
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (en[S_DIV0 + j])
            begin
                if (j == 0)
                begin
                    sing_div_reg[j] <= sing_chk_reg;
                end
                else
                begin
                    sing_div_reg[j] <= sing_div_reg[j-1];
                end
                if (j < DIV_STAGES - 1)
                begin
                    if (j == 0)
                    begin
                        dsor_reg[j] <= dchk_reg;
                    end
                    else
                    begin
                        dsor_reg[j] <= dsor_reg[j-1];
                    end
                end
            end
        end
        if (en[S_OUT])
        begin
            r_reg        <= r_next;
            sing_out_reg <= sing_div_reg[DIV_STAGES-1];
            sat_out_reg  <= sat_out_next;
        end
    end

    always_comb
    begin
        for (int j = 0; j < DIV_STAGES; j++)
        begin
            if (j == 0)
            begin
                dsor[j] = dchk_reg;
            end
            else
            begin
                dsor[j] = dsor_reg[j-1];
            end
        end
    end

    for (genvar g = 0; g < NEL; g++)
    begin : g_lane
        mi3_div_lane u_lane
        (
            .clk       (clk),
            .en        (en[S_OUT-1:S_DIV0]),
            .cm        (cm_chk_reg[g]),
            .dsor      (dsor),
            .flags     (fl_chk_reg[g]),
            .quo       (quo[g]),
            .flags_out (fl_out[g])
        );
    end

    // clip to the signed 32-bit range, identity for a singular matrix
    always_comb
    begin
        for (int k = 0; k < NEL; k++)
        begin
            sat_el[k] = 1'b0;
            if (fl_out[k].ovf)
            begin
                sat_el[k] = 1'b1;
                r_next[k] = fl_out[k].neg ? R_MIN : R_MAX;
            end
            else if (!fl_out[k].neg)
            begin
                sat_el[k] = quo[k] > R_MAX;
                r_next[k] = sat_el[k] ? R_MAX : quo[k];
            end
            else
            begin
                sat_el[k] = quo[k] > R_MIN;
                r_next[k] = sat_el[k] ? R_MIN : W'(-quo[k]);
            end
            if (sing_div_reg[DIV_STAGES-1])
            begin
                r_next[k] = (k % 4 == 0) ? ONE_Q16 : '0;
            end
        end
        sat_out_next = !sing_div_reg[DIV_STAGES-1] && (|sat_el);
    end

    assign inv.r11       = r_reg[0];
    assign inv.r12       = r_reg[1];
    assign inv.r13       = r_reg[2];
    assign inv.r21       = r_reg[3];
    assign inv.r22       = r_reg[4];
    assign inv.r23       = r_reg[5];
    assign inv.r31       = r_reg[6];
    assign inv.r32       = r_reg[7];
    assign inv.r33       = r_reg[8];
    assign inv.singular  = sing_out_reg;
    assign inv.saturated = sat_out_reg;

endmodule

`default_nettype wire

>>> tb/matrix3_inverse_unit_tb.sv
// ---------------------------------------------------------------------------
// matrix3_inverse_unit_tb
// Self-checking bench for the 3x3 matrix inverse unit: directed and random
// matrices with random stalls on both sides, predicted in exact fixed point.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module matrix3_inverse_unit_tb;
    import mi3_pkg::*;

    typedef struct {
        logic signed [31:0] e [9];
    } matrix_t;

    typedef struct {
        logic signed [31:0] r [9];
        logic               singular;
        logic               saturated;
    } inverse_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    mi3_mat_if mat ();
    mi3_inv_if inv ();
    mi3_cfg_if cfg ();

    matrix3_inverse_unit uut (.clk(clk), .rst_n(rst_n), .mat(mat), .inv(inv), .cfg(cfg));

    always #6 clk = ~clk;

    logic [62:0] threshold;
    inverse_t    expected_q [$];
    int          mismatches = 0;
    int          results_seen = 0;
    int          singular_seen = 0;
    int          saturated_seen = 0;
    int          idle_cycles = 0;
    bit          stalls_on = 1'b1;
    bit          hold_off = 1'b0;

    // exact prediction of one inverse
    function automatic inverse_t predict_inverse(matrix_t m);
        inverse_t           res;
        logic signed [63:0] e [9];
        logic signed [63:0] cof [9];
        logic signed [127:0] det;
        logic [127:0]        dmag;
        logic [127:0]        num;
        logic [127:0]        q;
        logic                neg;
        for (int i = 0; i < 9; i++)
            e[i] = m.e[i];
        cof[0] = e[4] * e[8] - e[5] * e[7];
        cof[1] = e[2] * e[7] - e[1] * e[8];
        cof[2] = e[1] * e[5] - e[2] * e[4];
        cof[3] = e[5] * e[6] - e[3] * e[8];
        cof[4] = e[0] * e[8] - e[2] * e[6];
        cof[5] = e[2] * e[3] - e[0] * e[5];
        cof[6] = e[3] * e[7] - e[4] * e[6];
        cof[7] = e[1] * e[6] - e[0] * e[7];
        cof[8] = e[0] * e[4] - e[1] * e[3];
        det = 128'(e[0]) * 128'(cof[0]) + 128'(e[1]) * 128'(cof[3])
            + 128'(e[2]) * 128'(cof[6]);
        dmag = det[127] ? -det : det;
        res.saturated = 1'b0;
        if (dmag == 0 || (dmag[127:64] == 0 && dmag[63:0] < {1'b0, threshold}))
        begin
            for (int i = 0; i < 9; i++)
                res.r[i] = (i % 4 == 0) ? 32'sd65536 : 32'sd0;
            res.singular = 1'b1;
            return res;
        end
        res.singular = 1'b0;
        for (int i = 0; i < 9; i++)
        begin
            num = {64'd0, (cof[i][63] ? -cof[i] : cof[i])} << 32;
            q = num / dmag;
            neg = cof[i][63] ^ det[127];
            if (!neg && q > 128'h7FFFFFFF)
            begin
                res.r[i] = R_MAX;
                res.saturated = 1'b1;
            end
            else if (neg && q > 128'h80000000)
            begin
                res.r[i] = R_MIN;
                res.saturated = 1'b1;
            end
            else
            begin
                res.r[i] = neg ? -q[31:0] : q[31:0];
            end
        end
        return res;
    endfunction

    task automatic report_mismatch(string what, int unsigned got, int unsigned want);
        $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    // an idle burst drops valid for its whole length
    task automatic random_idle();
        if (stalls_on && $urandom_range(0, 3) == 0)
        begin
            mat.valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
    endtask

    // valid stays up after a transaction so items can go back to back
    task automatic send_matrix(matrix_t m);
        random_idle();
        mat.valid <= 1'b1;
        {mat.m11, mat.m12, mat.m13, mat.m21, mat.m22, mat.m23, mat.m31, mat.m32, mat.m33}
            <= {m.e[0], m.e[1], m.e[2], m.e[3], m.e[4], m.e[5], m.e[6], m.e[7], m.e[8]};
        do @(posedge clk); while (!mat.ready);
        expected_q.push_back(predict_inverse(m));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        mat.valid <= 1'b0;
        while (expected_q.size() != 0) @(negedge clk);
        repeat (50) @(negedge clk);
    endtask

    task automatic write_threshold(logic [62:0] value);
        cfg.valid <= 1'b1;
        cfg.data  <= value;
        do @(posedge clk); while (!cfg.ready);
        threshold = value;
        @(negedge clk);
        cfg.valid <= 1'b0;
    endtask

    function automatic logic signed [31:0] rand_element(int kind);
        case (kind)
            0: return $urandom_range(0, 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            1: return $signed($urandom_range(0, 2 ** 20)) - 32'sd524288;
            2: return $signed($urandom_range(0, 2 ** 17)) - 32'sd65536;
            default: return $signed($urandom());
        endcase
    endfunction

    function automatic matrix_t rand_matrix();
        matrix_t m;
        int      kind;
        kind = $urandom_range(0, 5);
        for (int i = 0; i < 9; i++)
            m.e[i] = rand_element(kind == 5 ? $urandom_range(0, 3) : kind);
        // nearly singular: copy one row onto another, sometimes nudged
        if ($urandom_range(0, 7) == 0)
            for (int j = 0; j < 3; j++)
                m.e[6 + j] = m.e[3 + j] + ($urandom_range(0, 1) ? 32'sd1 : 32'sd0);
        return m;
    endfunction

    function automatic matrix_t diag_matrix(logic signed [31:0] a, logic signed [31:0] b,
                                            logic signed [31:0] c);
        matrix_t m;
        for (int i = 0; i < 9; i++)
            m.e[i] = 32'sd0;
        m.e[0] = a;
        m.e[4] = b;
        m.e[8] = c;
        return m;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        inverse_t want;
        if (rst_n && inv.valid && inv.ready)
        begin
            results_seen++;
            if (expected_q.size() == 0)
            begin
                $display("unexpected inverse transaction at %0t", $realtime);
                mismatches++;
            end
            else
            begin
                want = expected_q.pop_front();
                if (inv.singular) singular_seen++;
                if (inv.saturated) saturated_seen++;
                if (inv.r11 !== want.r[0]) report_mismatch("r11", inv.r11, want.r[0]);
                if (inv.r12 !== want.r[1]) report_mismatch("r12", inv.r12, want.r[1]);
                if (inv.r13 !== want.r[2]) report_mismatch("r13", inv.r13, want.r[2]);
                if (inv.r21 !== want.r[3]) report_mismatch("r21", inv.r21, want.r[3]);
                if (inv.r22 !== want.r[4]) report_mismatch("r22", inv.r22, want.r[4]);
                if (inv.r23 !== want.r[5]) report_mismatch("r23", inv.r23, want.r[5]);
                if (inv.r31 !== want.r[6]) report_mismatch("r31", inv.r31, want.r[6]);
                if (inv.r32 !== want.r[7]) report_mismatch("r32", inv.r32, want.r[7]);
                if (inv.r33 !== want.r[8]) report_mismatch("r33", inv.r33, want.r[8]);
                if (inv.singular !== want.singular)
                    report_mismatch("singular", inv.singular, want.singular);
                if (inv.saturated !== want.saturated)
                    report_mismatch("saturated", inv.saturated, want.saturated);
            end
        end
    end

    // output stalls, plus one long hold-off
    initial
    begin
        inv.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off)
            begin
                inv.ready <= 1'b0;
                repeat (200) @(negedge clk);
                hold_off = 1'b0;
                inv.ready <= 1'b1;
            end
            else if (stalls_on && $urandom_range(0, 7) == 0)
            begin
                inv.ready <= 1'b0;
                repeat ($urandom_range(1, 10) - 1) @(negedge clk);
            end
            else
            begin
                inv.ready <= 1'b1;
            end
        end
    end

    // watchdog on cycles without any accepted transaction
    always @(posedge clk)
    begin
        if ((mat.valid && mat.ready) || (inv.valid && inv.ready) || (cfg.valid && cfg.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000)
        begin
            $display("[matrix3_inverse_unit] ERROR");
            $finish;
        end
    end

    task automatic test_directed();
        matrix_t m;
        send_matrix(diag_matrix(32'sd65536, 32'sd65536, 32'sd65536));
        send_matrix(diag_matrix(32'sd131072, -32'sd65536, 32'sd32768));
        send_matrix(diag_matrix(32'sd0, 32'sd0, 32'sd0));
        send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
        send_matrix(diag_matrix(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        send_matrix(diag_matrix(32'sh80000000, 32'sh80000000, 32'sh80000000));
        send_matrix(diag_matrix(32'sh80000000, 32'sh7FFFFFFF, 32'sd1));
        send_matrix(diag_matrix(32'sd2, 32'sd65536, 32'sd65536));
        send_matrix(diag_matrix(-32'sd2, 32'sd65536, 32'sd65536));
        send_matrix(diag_matrix(32'sd4096, 32'sd4096, 32'sd65536));
        for (int i = 0; i < 9; i++) m.e[i] = 32'sh7FFFFFFF;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.e[i] = 32'sh80000000;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.e[i] = (i % 2) ? 32'sh80000000 : 32'sh7FFFFFFF;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.e[i] = $signed(32'(i * i + 1)) <<< 16;
        send_matrix(m);
        for (int i = 0; i < 9; i++) m.e[i] = 32'hFFFFFFFF;
        send_matrix(m);
        wait_drained();
    endtask

    task automatic test_thresholds();
        write_threshold(63'd0);
        send_matrix(diag_matrix(32'sd0, 32'sd65536, 32'sd65536));
        send_matrix(diag_matrix(32'sd1, 32'sd1, 32'sd1));
        wait_drained();
        write_threshold({63{1'b1}});
        send_matrix(diag_matrix(32'sd65536, 32'sd65536, 32'sd65536));
        send_matrix(diag_matrix(32'sh7FFFFFFF, 32'sh7FFFFFFF, 32'sh7FFFFFFF));
        for (int i = 0; i < 20; i++) send_matrix(rand_matrix());
        wait_drained();
        write_threshold(63'd1 << 48);
        send_matrix(diag_matrix(32'sd65536, 32'sd65536, 32'sd65536));
        send_matrix(diag_matrix(32'sd65536, 32'sd65536, 32'sd65535));
        wait_drained();
    endtask

    task automatic test_backpressure();
        hold_off = 1'b1;
        for (int i = 0; i < 80; i++) send_matrix(rand_matrix());
        wait_drained();
    endtask

    task automatic test_random(int count, bit with_stalls);
        stalls_on = with_stalls;
        for (int i = 0; i < count; i++)
        begin
            if (i % 100 == 50)
            begin
                wait_drained();
                write_threshold($urandom_range(0, 3) == 0
                                ? 63'({$urandom(), $urandom()} >> 1)
                                : 63'($urandom_range(0, 2 ** 24)));
            end
            send_matrix(rand_matrix());
        end
        wait_drained();
    endtask

    initial
    begin
        mat.valid = 1'b0;
        {mat.m11, mat.m12, mat.m13, mat.m21, mat.m22, mat.m23, mat.m31, mat.m32, mat.m33} = '0;
        cfg.valid = 1'b0;
        cfg.data = '0;
        threshold = THR_RESET;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_directed();
        test_thresholds();
        write_threshold(THR_RESET);
        test_backpressure();
        test_random(340, 1'b1);
        test_random(60, 1'b0);
        $display("covered %0d inverses, %0d singular, %0d saturated, several thresholds",
                 results_seen, singular_seen, saturated_seen);
        if (mismatches == 0)
            $display("[matrix3_inverse_unit] OK");
        else
            $display("[matrix3_inverse_unit] ERROR");
        $finish;
    end
endmodule
